>>> rtl/core/lfuttl_pkg.sv
`default_nettype none

package lfuttl_pkg;

    // Request codes
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_GET   = 3'd1;
    localparam logic [2:0] REQ_PUT   = 3'd2;
    localparam logic [2:0] REQ_INVAL = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL_SECONDS = 2'd1;
    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [15:0] TTL_SECONDS_RST = 16'd3600;

    localparam logic [15:0] AGE_MAX  = 16'hFFFF;
    localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] key_tag;
        logic [31:0] put_value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [31:0] read_hits;
        logic [4:0]  occupancy;
        logic [4:0]  removed;
    } t_rsp;

    // One slot's stored fields
    typedef struct packed {
        logic [63:0] tag;
        logic [31:0] value;
        logic [31:0] hits;
        logic [15:0] age;
    } t_slot;

    typedef struct packed {
        logic tag;
        logic value;
        logic hits;
        logic age;
    } t_slot_we;

    // Per-slot evaluation from the shared scan unit
    typedef struct packed {
        logic        expired;
        logic        tag_eq;
        logic        lower;
        logic        age_max;
        logic [15:0] age_inc;
        logic [31:0] hits_inc;
    } t_scan_eval;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_GET,
        ST_GET_FIN,
        ST_EVICT,
        ST_FIND,
        ST_PUT_WR,
        ST_INVAL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/lfuttl_slot_mem.sv
`default_nettype none

module lfuttl_slot_mem
    import lfuttl_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IW = $clog2(CAPACITY)
) (
    input  wire logic          i_clk,
    input  wire logic [IW-1:0] i_rd_addr,
    output t_slot              o_rd_data,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire t_slot_we      i_wr_we,
    input  wire t_slot         i_wr_data
);

    logic [63:0] r_mem_tag   [CAPACITY];
    logic [31:0] r_mem_value [CAPACITY];
    logic [31:0] r_mem_hits  [CAPACITY];
    logic [15:0] r_mem_age   [CAPACITY];

    // Write port, per-field enables
    always_ff @(posedge i_clk) begin
        if (i_wr_we.tag) begin
            r_mem_tag[i_wr_addr] <= i_wr_data.tag;
        end
        if (i_wr_we.value) begin
            r_mem_value[i_wr_addr] <= i_wr_data.value;
        end
        if (i_wr_we.hits) begin
            r_mem_hits[i_wr_addr] <= i_wr_data.hits;
        end
        if (i_wr_we.age) begin
            r_mem_age[i_wr_addr] <= i_wr_data.age;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data.tag   <= r_mem_tag[i_rd_addr];
        o_rd_data.value <= r_mem_value[i_rd_addr];
        o_rd_data.hits  <= r_mem_hits[i_rd_addr];
        o_rd_data.age   <= r_mem_age[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/lfuttl_scan_unit.sv
`default_nettype none

module lfuttl_scan_unit
    import lfuttl_pkg::*;
(
    input  wire t_slot         i_slot,
    input  wire logic          i_valid,
    input  wire logic [63:0]   i_key,
    input  wire logic [15:0]   i_ttl,
    input  wire logic          i_best_vld,
    input  wire logic [31:0]   i_best_hits,
    output t_scan_eval         o_eval
);

    // Compares, an age increment and a saturating hit count increment for the slot under scan
    always_comb begin
        o_eval.expired  = i_valid && (i_slot.age > i_ttl);
        o_eval.tag_eq   = i_valid && (i_slot.tag == i_key);
        o_eval.lower    = i_valid && (!i_best_vld || (i_slot.hits < i_best_hits));
        o_eval.age_max  = (i_slot.age == AGE_MAX);
        o_eval.age_inc  = i_slot.age + 16'd1;
        o_eval.hits_inc = (i_slot.hits == HITS_MAX) ? i_slot.hits : i_slot.hits + 32'd1;
    end

endmodule

`default_nettype wire

>>> rtl/core/lfu_cache_with_ttl_expiry_core.sv
`default_nettype none

// LFU result cache with TTL expiry, CAPACITY fully associative slots.
// Request channel: an item transfers when start is high and busy is low.
// busy stays high until the result has been issued. The result shows on
// o_rsp for one cycle with o_rsp_strobe high; the receiver cannot stall it.
// Config channel: i_cfg_valid/o_cfg_ready (always ready), i_cfg_index
// 0 = max_entries, 1 = ttl_seconds; other indexes are ignored. Write only
// while busy is low.
// Every slot walk reads the slots in index order, one read per cycle,
// from the slot memory, whose read port is registered.
// Sequence from transfer to strobe:
//   tick, invalidate: one walk, then the result
//   get, hit or miss: one walk, the hit count write-back step, then the result
//   put: one walk per entry evicted, a find walk, the write, then the result
//   clear, unknown request: the result only
// One item is in flight at a time; the next may transfer in the strobe cycle.
// Reset empties the cache and loads max_entries = 16, ttl_seconds = 3600.
// No clearing pass is needed: slot contents are read only while valid.
module lfu_cache_with_ttl_expiry_core
    import lfuttl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_req                  i_req,
    output t_rsp                       o_rsp,
    output logic                       o_rsp_strobe,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    // Control state
    t_state          r_state, n_state;
    logic [4:0]      r_max;
    logic [15:0]     r_ttl;
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [CW-1:0]   r_occ, n_occ;
    logic [CW-1:0]   r_removed, n_removed;
    logic [CW-1:0]   r_todo, n_todo;
    logic [CW-1:0]   r_done, n_done;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_issuing, n_issuing;
    logic            r_rd_vld, n_rd_vld;
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_found, n_found;
    logic            r_free_vld, n_free_vld;
    logic            r_best_vld, n_best_vld;
    logic            r_hit, n_hit;
    logic            r_strobe, n_strobe;

    // Payload state
    logic [63:0]     r_key, n_key;
    logic [31:0]     r_put_val, n_put_val;
    logic [IW-1:0]   r_slot, n_slot;
    logic [IW-1:0]   r_free_idx, n_free_idx;
    logic [IW-1:0]   r_best_idx, n_best_idx;
    logic [31:0]     r_best_hits, n_best_hits;
    logic [31:0]     r_rval, n_rval;
    logic [31:0]     r_rhits, n_rhits;
    t_rsp            r_rsp, n_rsp;

    // Memory and scan unit hookup
    t_slot           w_rd_data;
    t_slot_we        w_we;
    t_slot           w_wr_data;
    logic [IW-1:0]   w_wr_addr;
    t_scan_eval      w_eval;
    logic            w_cur_valid;
    logic            w_last;

    // Eviction count
    logic [31:0]     w_occ32;
    logic [31:0]     w_lim32;
    logic [31:0]     w_todo32;
    logic [31:0]     w_rem32;

    lfuttl_slot_mem #(
        .CAPACITY (CAPACITY)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data),
        .i_wr_addr (w_wr_addr),
        .i_wr_we   (w_we),
        .i_wr_data (w_wr_data)
    );

    assign w_cur_valid = r_valid[r_rd_idx];
    assign w_last      = r_rd_vld && (r_rd_idx == LAST_IDX);

    lfuttl_scan_unit u_scan_unit (
        .i_slot      (w_rd_data),
        .i_valid     (w_cur_valid),
        .i_key       (r_key),
        .i_ttl       (r_ttl),
        .i_best_vld  (r_best_vld),
        .i_best_hits (r_best_hits),
        .o_eval      (w_eval)
    );

    // Number of entries a put must evict
    always_comb begin
        w_occ32 = 32'(r_occ);
        w_lim32 = (32'(r_max) < 32'(CAPACITY)) ? 32'(r_max) : 32'(CAPACITY);
        w_todo32 = (w_occ32 >= w_lim32) ? (w_occ32 - w_lim32 + 32'd1) : 32'd0;
        if (w_todo32 > w_occ32) begin
            w_todo32 = w_occ32;
        end
        w_rem32 = 32'(r_removed);
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_rsp        = r_rsp;
    assign o_rsp_strobe = r_strobe;

    // Sequencer: next state, slot walk and memory writes
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_removed   = r_removed;
        n_todo      = r_todo;
        n_done      = r_done;
        n_found     = r_found;
        n_free_vld  = r_free_vld;
        n_best_vld  = r_best_vld;
        n_hit       = r_hit;
        n_strobe    = 1'b0;
        n_key       = r_key;
        n_put_val   = r_put_val;
        n_slot      = r_slot;
        n_free_idx  = r_free_idx;
        n_best_idx  = r_best_idx;
        n_best_hits = r_best_hits;
        n_rval      = r_rval;
        n_rhits     = r_rhits;
        n_rsp       = r_rsp;
        w_we        = '0;
        w_wr_addr   = r_rd_idx;
        w_wr_data   = w_rd_data;

        // Walk: issue one read per cycle, data comes back in the next cycle
        n_idx     = r_idx;
        n_issuing = r_issuing;
        n_rd_vld  = r_issuing;
        n_rd_idx  = r_idx;
        if (r_issuing) begin
            n_idx = r_idx + IW'(1);
            if (r_idx == LAST_IDX) begin
                n_issuing = 1'b0;
                n_idx     = '0;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_key      = i_req.key_tag;
                    n_put_val  = i_req.put_value;
                    n_removed  = '0;
                    n_done     = '0;
                    n_hit      = 1'b0;
                    n_rval     = '0;
                    n_rhits    = '0;
                    n_found    = 1'b0;
                    n_free_vld = 1'b0;
                    n_best_vld = 1'b0;
                    n_idx      = '0;
                    n_issuing  = 1'b1;
                    unique case (i_req.req_type)
                        REQ_TICK:  n_state = ST_TICK;
                        REQ_GET:   n_state = ST_GET;
                        REQ_PUT: begin
                            n_todo  = CW'(w_todo32);
                            n_state = (w_todo32 == 32'd0) ? ST_FIND : ST_EVICT;
                        end
                        REQ_INVAL: n_state = ST_INVAL;
                        REQ_CLEAR: begin
                            n_valid   = '0;
                            n_occ     = '0;
                            n_issuing = 1'b0;
                            n_state   = ST_DONE;
                        end
                        default: begin
                            n_issuing = 1'b0;
                            n_state   = ST_DONE;
                        end
                    endcase
                end
            end

            // Age every valid slot, saturating
            ST_TICK: begin
                if (r_rd_vld && w_cur_valid && !w_eval.age_max) begin
                    w_we.age      = 1'b1;
                    w_wr_data.age = w_eval.age_inc;
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end

            // Expire old slots and look up the key in one walk
            ST_GET: begin
                if (r_rd_vld) begin
                    if (w_eval.expired) begin
                        n_valid[r_rd_idx] = 1'b0;
                        n_occ             = r_occ - CW'(1);
                        n_removed         = r_removed + CW'(1);
                    end else if (w_eval.tag_eq && !r_found) begin
                        n_found = 1'b1;
                        n_slot  = r_rd_idx;
                        n_rval  = w_rd_data.value;
                        n_rhits = w_eval.hits_inc;
                    end
                end
                if (w_last) begin
                    n_state = ST_GET_FIN;
                end
            end

            ST_GET_FIN: begin
                if (r_found) begin
                    n_hit          = 1'b1;
                    w_we.hits      = 1'b1;
                    w_wr_addr      = r_slot;
                    w_wr_data.hits = r_rhits;
                end
                n_state = ST_DONE;
            end

            // One walk per evicted entry: lowest hit count, lowest slot
            ST_EVICT: begin
                if (r_rd_vld && w_eval.lower) begin
                    n_best_vld  = 1'b1;
                    n_best_idx  = r_rd_idx;
                    n_best_hits = w_rd_data.hits;
                end
                if (w_last) begin
                    n_best_vld = 1'b0;
                    n_idx      = '0;
                    n_issuing  = 1'b1;
                    if (w_eval.lower || r_best_vld) begin
                        n_valid[w_eval.lower ? r_rd_idx : r_best_idx] = 1'b0;
                        n_occ     = r_occ - CW'(1);
                        n_removed = r_removed + CW'(1);
                        n_done    = r_done + CW'(1);
                    end
                    if (!(w_eval.lower || r_best_vld) || ((r_done + CW'(1)) == r_todo)) begin
                        n_state = ST_FIND;
                    end
                end
            end

            // Find the key or the lowest free slot
            ST_FIND: begin
                if (r_rd_vld) begin
                    if (w_eval.tag_eq && !r_found) begin
                        n_found = 1'b1;
                        n_slot  = r_rd_idx;
                    end
                    if (!w_cur_valid && !r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_rd_idx;
                    end
                end
                if (w_last) begin
                    n_state = ST_PUT_WR;
                end
            end

            ST_PUT_WR: begin
                w_wr_data.tag   = r_key;
                w_wr_data.value = r_put_val;
                w_wr_data.hits  = 32'd1;
                w_wr_data.age   = 16'd0;
                if (r_found) begin
                    w_we      = '1;
                    w_wr_addr = r_slot;
                end else if (r_free_vld) begin
                    w_we                = '1;
                    w_wr_addr           = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_occ               = r_occ + CW'(1);
                end
                n_state = ST_DONE;
            end

            ST_INVAL: begin
                if (r_rd_vld && w_eval.tag_eq && !r_found) begin
                    n_found           = 1'b1;
                    n_valid[r_rd_idx] = 1'b0;
                    n_occ             = r_occ - CW'(1);
                end
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                n_rsp.hit        = r_hit;
                n_rsp.read_value = r_rval & {32{r_hit}};
                n_rsp.read_hits  = r_rhits & {32{r_hit}};
                n_rsp.occupancy  = w_occ32[4:0];
                n_rsp.removed    = w_rem32[4:0];
                n_strobe         = 1'b1;
                n_state          = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= MAX_ENTRIES_RST;
            r_ttl      <= TTL_SECONDS_RST;
            r_valid    <= '0;
            r_occ      <= '0;
            r_removed  <= '0;
            r_todo     <= '0;
            r_done     <= '0;
            r_idx      <= '0;
            r_issuing  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_found    <= 1'b0;
            r_free_vld <= 1'b0;
            r_best_vld <= 1'b0;
            r_hit      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_ENTRIES: r_max <= i_cfg_data[4:0];
                    CFG_TTL_SECONDS: r_ttl <= i_cfg_data;
                    default: ;
                endcase
            end
            r_valid    <= n_valid;
            r_occ      <= n_occ;
            r_removed  <= n_removed;
            r_todo     <= n_todo;
            r_done     <= n_done;
            r_idx      <= n_idx;
            r_issuing  <= n_issuing;
            r_rd_vld   <= n_rd_vld;
            r_rd_idx   <= n_rd_idx;
            r_found    <= n_found;
            r_free_vld <= n_free_vld;
            r_best_vld <= n_best_vld;
            r_hit      <= n_hit;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_put_val   <= n_put_val;
        r_slot      <= n_slot;
        r_free_idx  <= n_free_idx;
        r_best_idx  <= n_best_idx;
        r_best_hits <= n_best_hits;
        r_rval      <= n_rval;
        r_rhits     <= n_rhits;
        r_rsp       <= n_rsp;
    end

    // Occupancy counter tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) == $countones(r_valid))
        else $error("occupancy counter out of step with valid bits");

    // Busy drops only as the result is issued
    a_done_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_rsp_strobe)
        else $error("busy fell without a result");

    // Strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_strobe |=> !o_rsp_strobe)
        else $error("result strobe held for two cycles");

    // Eviction never goes past its target
    a_evict_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT) |-> (r_done < r_todo))
        else $error("eviction count overran");

endmodule

`default_nettype wire
